>>> sv/assert_macros.svh
// Assertion helpers for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising clock edge, off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must never be true on a rising clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

>>> sv/msn_pkg.sv
package msn_pkg;

   // Table geometry
   localparam int SONGS          = 8;
   localparam int NOTES_PER_SONG = 256;
   localparam int SONG_W         = $clog2(SONGS);
   localparam int NOTE_AW        = $clog2(NOTES_PER_SONG);
   localparam int TABLE_AW       = SONG_W + NOTE_AW;
   localparam int TABLE_DEPTH    = 2 ** TABLE_AW;

   // Field widths
   localparam int IDX_W   = 9;
   localparam int FREQ_W  = 16;
   localparam int DUR_W   = 16;
   localparam int CNT_W   = 4;
   localparam int TEMPO_W = 8;

   // Tempo limits and divide-by-100 reciprocal: floor(p / 100) = (p * RECIP) >> 30
   // holds for every product p below 14,000,000; the largest, 65535 * 175, is
   // about 11.5 million
   localparam logic signed [TEMPO_W-1:0] TEMPO_MIN = -8'sd75;
   localparam logic signed [TEMPO_W-1:0] TEMPO_MAX = 8'sd75;
   localparam int PROD_W      = DUR_W + TEMPO_W;
   localparam int RECIP_W     = 24;
   localparam int RECIP_SHIFT = 30;
   localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
   localparam int SCALE_W     = PROD_W + RECIP_W;

   typedef enum logic [2:0] {
      REQ_TICK    = 3'd0,
      REQ_PLAY    = 3'd1,
      REQ_STOP    = 3'd2,
      REQ_NEXT    = 3'd3,
      REQ_PREV    = 3'd4,
      REQ_WR_NOTE = 3'd5,
      REQ_WR_LEN  = 3'd6
   } msn_req_code_type;

   typedef enum logic [1:0] {
      EV_NONE = 2'd0,
      EV_NOTE = 2'd1,
      EV_SONG = 2'd2
   } msn_event_type;

   typedef enum logic [1:0] {
      CSR_SONG_COUNT = 2'd0,
      CSR_TEMPO      = 2'd1,
      CSR_MUTE       = 2'd2
   } msn_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCALE,
      ST_SAT,
      ST_DONE
   } msn_state_type;

   typedef struct packed {
      logic [2:0]        req_type;
      logic [2:0]        song_sel;
      logic [7:0]        entry_index;
      logic [FREQ_W-1:0] note_value;
      logic [DUR_W-1:0]  duration_value;
      logic [IDX_W-1:0]  length_value;
   } msn_req_type;

   typedef struct packed {
      logic [FREQ_W-1:0] tone_freq;
      logic              tone_on;
      logic [1:0]        event_res;
      logic [2:0]        song_now;
      logic [IDX_W-1:0]  note_now;
      logic              is_playing;
   } msn_rsp_type;

endpackage

>>> sv/melody_note_sequencer.sv
// Items that load no note go from the transfer through ST_DONE to the result;
// play, next, prev and note-advancing ticks first pass the table read, two
// multiply stages for the tempo scaling and saturation (READ, SCALE, SAT).
// A new item is taken only after the last result has been registered.
// Reset: synchronous, clears playback state and registers (song_count 1);
// note, duration and length tables are not cleared, no clearing pass.
`include "assert_macros.svh"

module melody_note_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  msn_pkg::msn_req_type     req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output msn_pkg::msn_rsp_type     rsp_data,
   input  logic                     csr_wr_en,
   input  logic [1:0]               csr_index,
   input  logic [7:0]               csr_wdata
);

   // Control and playback state
   msn_pkg::msn_state_type state_ff, state_in;
   msn_pkg::msn_event_type ev_ff, ev_in;
   logic                                running_ff, running_in;
   logic [msn_pkg::SONG_W-1:0]          song_ff, song_in;
   logic [msn_pkg::IDX_W-1:0]           note_ff, note_in;
   logic [msn_pkg::DUR_W-1:0]           elapsed_ff, elapsed_in;
   logic [msn_pkg::DUR_W-1:0]           note_len_ff, note_len_in;
   logic [msn_pkg::FREQ_W-1:0]          freq_ff, freq_in;

   // Configuration registers
   logic [msn_pkg::CNT_W-1:0]           song_count_ff, song_count_in;
   logic signed [msn_pkg::TEMPO_W-1:0]  tempo_ff, tempo_in;
   logic                                mute_ff, mute_in;

   // Scaling pipeline
   logic [msn_pkg::PROD_W-1:0]          prod_ff, prod_in;
   logic [msn_pkg::SCALE_W-1:0]         scale_ff, scale_in;

   // Result register
   logic                                rsp_valid_ff, rsp_valid_in;
   msn_pkg::msn_rsp_type                rsp_ff, rsp_in;

   // Memories
   logic [msn_pkg::FREQ_W+msn_pkg::DUR_W-1:0] tbl_mem [msn_pkg::TABLE_DEPTH];
   logic [msn_pkg::FREQ_W+msn_pkg::DUR_W-1:0] mem_rd_ff;
   logic [msn_pkg::IDX_W-1:0]           len_mem [msn_pkg::SONGS];
   logic                                mem_we, mem_rd_en, len_we;
   logic [msn_pkg::TABLE_AW-1:0]        mem_wr_addr, mem_rd_addr;

   // Helper values
   logic                                req_xfer;
   logic [msn_pkg::CNT_W-1:0]           songs_used;
   logic [msn_pkg::SONG_W-1:0]          song_nxt, song_prv;
   logic [msn_pkg::IDX_W-1:0]           len_raw, len_eff, note_inc;
   logic [msn_pkg::DUR_W-1:0]           elapsed_inc;
   logic [msn_pkg::TEMPO_W-1:0]         factor;
   logic [msn_pkg::DUR_W-1:0]           rd_dur;
   logic [msn_pkg::FREQ_W-1:0]          rd_note;
   logic [msn_pkg::SCALE_W-msn_pkg::RECIP_SHIFT-1:0] quot;
   logic                                tone_on;

   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Songs in use: zero acts as one, large counts clamp to the table size
   always_comb begin
      if (song_count_ff == '0) begin
         songs_used = msn_pkg::CNT_W'(1);
      end else if (song_count_ff > msn_pkg::CNT_W'(msn_pkg::SONGS)) begin
         songs_used = msn_pkg::CNT_W'(msn_pkg::SONGS);
      end else begin
         songs_used = song_count_ff;
      end
   end

   // Next and previous song with wrap at both ends
   always_comb begin
      if (msn_pkg::CNT_W'(song_ff) + msn_pkg::CNT_W'(1) >= songs_used) begin
         song_nxt = '0;
      end else begin
         song_nxt = song_ff + msn_pkg::SONG_W'(1);
      end
      if (song_ff == '0 || msn_pkg::CNT_W'(song_ff) >= songs_used) begin
         song_prv = msn_pkg::SONG_W'(songs_used - msn_pkg::CNT_W'(1));
      end else begin
         song_prv = song_ff - msn_pkg::SONG_W'(1);
      end
   end

   // Current song length, clamped to the table row size
   assign len_raw = len_mem[song_ff];
   assign len_eff = (len_raw > msn_pkg::IDX_W'(msn_pkg::NOTES_PER_SONG)) ?
                    msn_pkg::IDX_W'(msn_pkg::NOTES_PER_SONG) : len_raw;
   assign note_inc    = note_ff + msn_pkg::IDX_W'(1);
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + msn_pkg::DUR_W'(1);

   // Tempo factor 100 - tempo, always in 25..175
   assign factor = 8'(9'sd100 - {tempo_ff[msn_pkg::TEMPO_W-1], tempo_ff});

   assign rd_note = mem_rd_ff[msn_pkg::FREQ_W+msn_pkg::DUR_W-1:msn_pkg::DUR_W];
   assign rd_dur  = mem_rd_ff[msn_pkg::DUR_W-1:0];
   assign quot    = scale_ff[msn_pkg::SCALE_W-1:msn_pkg::RECIP_SHIFT];
   assign tone_on = running_ff && !mute_ff;

   // Configuration writes
   always_comb begin
      song_count_in = song_count_ff;
      tempo_in      = tempo_ff;
      mute_in       = mute_ff;
      if (csr_wr_en) begin
         unique case (msn_pkg::msn_csr_type'(csr_index))
            msn_pkg::CSR_SONG_COUNT: begin
               song_count_in = csr_wdata[msn_pkg::CNT_W-1:0];
            end
            msn_pkg::CSR_TEMPO: begin
               if ($signed(csr_wdata) >= msn_pkg::TEMPO_MIN &&
                   $signed(csr_wdata) <= msn_pkg::TEMPO_MAX) begin
                  tempo_in = $signed(csr_wdata);
               end
            end
            msn_pkg::CSR_MUTE: begin
               mute_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer: next state, state updates and memory accesses
   always_comb begin
      state_in     = state_ff;
      ev_in        = ev_ff;
      running_in   = running_ff;
      song_in      = song_ff;
      note_in      = note_ff;
      elapsed_in   = elapsed_ff;
      note_len_in  = note_len_ff;
      freq_in      = freq_ff;
      prod_in      = prod_ff;
      scale_in     = scale_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_rd_en    = 1'b0;
      len_we       = 1'b0;
      mem_wr_addr  = {req_data.song_sel[msn_pkg::SONG_W-1:0],
                      req_data.entry_index[msn_pkg::NOTE_AW-1:0]};
      unique case (state_ff)
         msn_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_xfer) begin
               ev_in    = msn_pkg::EV_NONE;
               state_in = msn_pkg::ST_DONE;
               unique case (msn_pkg::msn_req_code_type'(req_data.req_type))
                  msn_pkg::REQ_TICK: begin
                     if (running_ff) begin
                        elapsed_in = elapsed_inc;
                        if (elapsed_inc >= note_len_ff) begin
                           if (note_inc >= len_eff) begin
                              song_in = song_nxt;
                              note_in = '0;
                              ev_in   = msn_pkg::EV_SONG;
                           end else begin
                              note_in = note_inc;
                              ev_in   = msn_pkg::EV_NOTE;
                           end
                           mem_rd_en = 1'b1;
                           state_in  = msn_pkg::ST_READ;
                        end
                     end
                  end
                  msn_pkg::REQ_PLAY: begin
                     song_in    = '0;
                     note_in    = '0;
                     running_in = 1'b1;
                     mem_rd_en  = 1'b1;
                     state_in   = msn_pkg::ST_READ;
                  end
                  msn_pkg::REQ_STOP: begin
                     note_in    = '0;
                     running_in = 1'b0;
                  end
                  msn_pkg::REQ_NEXT: begin
                     song_in    = song_nxt;
                     note_in    = '0;
                     running_in = 1'b1;
                     mem_rd_en  = 1'b1;
                     state_in   = msn_pkg::ST_READ;
                  end
                  msn_pkg::REQ_PREV: begin
                     song_in    = song_prv;
                     note_in    = '0;
                     running_in = 1'b1;
                     mem_rd_en  = 1'b1;
                     state_in   = msn_pkg::ST_READ;
                  end
                  msn_pkg::REQ_WR_NOTE: begin
                     mem_we = (4'(req_data.song_sel) < 4'(msn_pkg::SONGS)) &&
                              (9'(req_data.entry_index) <
                               9'(msn_pkg::NOTES_PER_SONG));
                  end
                  msn_pkg::REQ_WR_LEN: begin
                     len_we = 4'(req_data.song_sel) < 4'(msn_pkg::SONGS);
                  end
                  default: begin
                  end
               endcase
            end
         end
         msn_pkg::ST_READ: begin
            prod_in  = msn_pkg::PROD_W'(rd_dur * factor);
            state_in = msn_pkg::ST_SCALE;
         end
         msn_pkg::ST_SCALE: begin
            scale_in = msn_pkg::SCALE_W'(prod_ff * msn_pkg::RECIP_100);
            state_in = msn_pkg::ST_SAT;
         end
         msn_pkg::ST_SAT: begin
            // Latch the loaded note and restart timing
            note_len_in = (quot > msn_pkg::DUR_W'('1)) ? '1 : msn_pkg::DUR_W'(quot);
            freq_in     = rd_note;
            elapsed_in  = '0;
            state_in    = msn_pkg::ST_DONE;
         end
         msn_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.tone_freq  = tone_on ? freq_ff : '0;
               rsp_in.tone_on    = tone_on;
               rsp_in.event_res  = ev_ff;
               rsp_in.song_now   = 3'(song_ff);
               rsp_in.note_now   = note_ff;
               rsp_in.is_playing = running_ff;
               state_in          = msn_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = msn_pkg::ST_IDLE;
         end
      endcase
      mem_rd_addr = {song_in, note_in[msn_pkg::NOTE_AW-1:0]};
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= msn_pkg::ST_IDLE;
         ev_ff         <= msn_pkg::EV_NONE;
         running_ff    <= 1'b0;
         song_ff       <= '0;
         note_ff       <= '0;
         elapsed_ff    <= '0;
         note_len_ff   <= '0;
         freq_ff       <= '0;
         song_count_ff <= msn_pkg::CNT_W'(1);
         tempo_ff      <= '0;
         mute_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ev_ff         <= ev_in;
         running_ff    <= running_in;
         song_ff       <= song_in;
         note_ff       <= note_in;
         elapsed_ff    <= elapsed_in;
         note_len_ff   <= note_len_in;
         freq_ff       <= freq_in;
         song_count_ff <= song_count_in;
         tempo_ff      <= tempo_in;
         mute_ff       <= mute_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      scale_ff <= scale_in;
      rsp_ff   <= rsp_in;
   end

   // Note and duration table, one write or one read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tbl_mem[mem_wr_addr] <= {req_data.note_value, req_data.duration_value};
      end
      if (mem_rd_en) begin
         mem_rd_ff <= tbl_mem[mem_rd_addr];
      end
   end

   // Song length table
   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[req_data.song_sel[msn_pkg::SONG_W-1:0]] <= req_data.length_value;
      end
   end

   // Checks
   `ASSERT_CLK(a_rd_then_scale, clock, reset, mem_rd_en |=> state_ff == msn_pkg::ST_READ, "table read not followed by scaling")
   `ASSERT_CLK(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == msn_pkg::ST_DONE), "result without a finished item")
   `ASSERT_CLK(a_silent_zero, clock, reset, (rsp_valid_ff && !rsp_ff.tone_on) |-> rsp_ff.tone_freq == '0, "silent result carries a tone")
   `ASSERT_CLK(a_song_evt_note0, clock, reset, (rsp_valid_ff && rsp_ff.event_res == msn_pkg::EV_SONG) |-> rsp_ff.note_now == '0, "song change not at first note")
   `ASSERT_NEVER(a_no_rw_clash, clock, reset, mem_we && mem_rd_en, "table read and write in one cycle")

endmodule
